// ----- hdl/bps_pkg.sv -----
// Package: shared types and constants for the BSP point-in-solid block.
package bps_pkg;

	localparam int NODE_COUNT   = 1024;
	localparam int FACE_COUNT   = 4096;
	localparam int VERTEX_COUNT = 4096;
	localparam int NODE_AW      = $clog2(NODE_COUNT);
	localparam int FACE_AW      = $clog2(FACE_COUNT);
	localparam int VERT_AW      = $clog2(VERTEX_COUNT);

	localparam logic [15:0] LINK_SOLID = 16'hFFFF;
	localparam logic [15:0] LINK_EMPTY = 16'hFFFE;
	localparam logic [12:0] LIMIT_MAX  = 13'd4096;
	localparam logic [12:0] LIMIT_RST  = 13'd1024;

	// input tdata: index, x, y, z, plane_face, link_above, link_below, first_vertex
	localparam int IN_BITS  = 12 + 32 * 3 + 12 + 16 + 16 + 12;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W    = 16;

	typedef enum logic [1:0] {
		CMD_NODE   = 2'd0,
		CMD_FACE   = 2'd1,
		CMD_VERTEX = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_LIMIT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		W_IDLE,
		W_NODE,
		W_FACE,
		W_VERT,
		W_MUL,
		W_SUM,
		W_ADD,
		W_DECIDE,
		W_DONE
	} walk_state_t;

	// one classified item handed from the front part to the walker
	typedef struct packed {
		cmd_t        cmd;
		logic [11:0] index;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [11:0] plane_face;
		logic [15:0] link_above;
		logic [15:0] link_below;
		logic [11:0] first_vertex;
		logic        in_range;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	typedef struct packed {
		logic        inside_res;
		status_t     status;
		logic [12:0] steps_taken;
	} result_t;

endpackage

// ----- hdl/bps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/bps_front.sv -----
// Front part: accepts items, classifies them and feeds a two-entry queue.
module bps_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [1:0]                s_tuser,
	input  logic [bps_pkg::IN_W-1:0]  s_tdata,
	output logic                      q_valid,
	input  logic                      q_ready,
	output bps_pkg::item_t            q_item
);

	bps_pkg::item_t cls;
	bps_pkg::item_t ent_q [2];
	logic           rd_q, wr_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	// unpack and range-check the write slot
	always_comb begin
		cls.cmd          = bps_pkg::cmd_t'(s_tuser);
		cls.index        = s_tdata[11:0];
		cls.x            = s_tdata[43:12];
		cls.y            = s_tdata[75:44];
		cls.z            = s_tdata[107:76];
		cls.plane_face   = s_tdata[119:108];
		cls.link_above   = s_tdata[135:120];
		cls.link_below   = s_tdata[151:136];
		cls.first_vertex = s_tdata[163:152];
		case (cls.cmd)
			bps_pkg::CMD_NODE:   cls.in_range = {4'd0, cls.index} < 16'(bps_pkg::NODE_COUNT);
			bps_pkg::CMD_FACE:   cls.in_range = {5'd0, cls.index} < 17'(bps_pkg::FACE_COUNT);
			bps_pkg::CMD_VERTEX: cls.in_range = {5'd0, cls.index} < 17'(bps_pkg::VERTEX_COUNT);
			default:             cls.in_range = 1'b1;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = ent_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- hdl/bps_walk.sv -----
// Back part: store writes and the tree walk with its output register.
module bps_walk (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [12:0]           step_limit,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  bps_pkg::item_t        q_item,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [bps_pkg::OUT_W-1:0] m_tdata
);

	localparam int NAW = bps_pkg::NODE_AW;
	localparam int FAW = bps_pkg::FACE_AW;
	localparam int VAW = bps_pkg::VERT_AW;

	bps_pkg::walk_state_t st_q, st_nx;
	bps_pkg::item_t       it_q;
	logic [NAW-1:0]       walk_node_q;
	logic [12:0]          steps_q, limit_q;
	logic [31:0]          nx_q, ny_q, nz_q;
	logic [15:0]          la_q, lb_q;
	logic signed [32:0]   ox_q, oy_q, oz_q;
	logic signed [65:0]   px_q, py_q, pz_q;
	logic signed [67:0]   sum_q;
	bps_pkg::result_t     res_q;
	logic                 out_v_q;

	// memory ports
	logic        wr_node, wr_face, wr_vert;
	logic [31:0] rnx, rny, rnz, rvx, rvy, rvz;
	logic [11:0] rpf, rfv;
	logic [15:0] rla, rlb;
	logic [FAW-1:0] face_addr;
	logic [VAW-1:0] vert_addr;

	logic take;
	logic [15:0] link;
	logic [12:0] lim;

	assign take    = q_valid && q_ready;
	assign q_ready = (st_q == bps_pkg::W_IDLE) && !out_v_q;
	assign wr_node = take && q_item.cmd == bps_pkg::CMD_NODE && q_item.in_range;
	assign wr_face = take && q_item.cmd == bps_pkg::CMD_FACE && q_item.in_range;
	assign wr_vert = take && q_item.cmd == bps_pkg::CMD_VERTEX && q_item.in_range;

	assign face_addr = FAW'(rpf);
	assign vert_addr = VAW'(rfv);

	bps_ram #(.WIDTH(32), .DEPTH(bps_pkg::NODE_COUNT)) u_nx (.clk, .we(wr_node),
		.waddr(NAW'(q_item.index)), .wdata(q_item.x), .raddr(walk_node_q), .rdata(rnx));
	bps_ram #(.WIDTH(32), .DEPTH(bps_pkg::NODE_COUNT)) u_ny (.clk, .we(wr_node),
		.waddr(NAW'(q_item.index)), .wdata(q_item.y), .raddr(walk_node_q), .rdata(rny));
	bps_ram #(.WIDTH(32), .DEPTH(bps_pkg::NODE_COUNT)) u_nz (.clk, .we(wr_node),
		.waddr(NAW'(q_item.index)), .wdata(q_item.z), .raddr(walk_node_q), .rdata(rnz));
	bps_ram #(.WIDTH(12), .DEPTH(bps_pkg::NODE_COUNT)) u_pf (.clk, .we(wr_node),
		.waddr(NAW'(q_item.index)), .wdata(q_item.plane_face), .raddr(walk_node_q),
		.rdata(rpf));
	bps_ram #(.WIDTH(16), .DEPTH(bps_pkg::NODE_COUNT)) u_la (.clk, .we(wr_node),
		.waddr(NAW'(q_item.index)), .wdata(q_item.link_above), .raddr(walk_node_q),
		.rdata(rla));
	bps_ram #(.WIDTH(16), .DEPTH(bps_pkg::NODE_COUNT)) u_lb (.clk, .we(wr_node),
		.waddr(NAW'(q_item.index)), .wdata(q_item.link_below), .raddr(walk_node_q),
		.rdata(rlb));
	bps_ram #(.WIDTH(12), .DEPTH(bps_pkg::FACE_COUNT)) u_fv (.clk, .we(wr_face),
		.waddr(FAW'(q_item.index)), .wdata(q_item.first_vertex), .raddr(face_addr),
		.rdata(rfv));
	bps_ram #(.WIDTH(32), .DEPTH(bps_pkg::VERTEX_COUNT)) u_vx (.clk, .we(wr_vert),
		.waddr(VAW'(q_item.index)), .wdata(q_item.x), .raddr(vert_addr), .rdata(rvx));
	bps_ram #(.WIDTH(32), .DEPTH(bps_pkg::VERTEX_COUNT)) u_vy (.clk, .we(wr_vert),
		.waddr(VAW'(q_item.index)), .wdata(q_item.y), .raddr(vert_addr), .rdata(rvy));
	bps_ram #(.WIDTH(32), .DEPTH(bps_pkg::VERTEX_COUNT)) u_vz (.clk, .we(wr_vert),
		.waddr(VAW'(q_item.index)), .wdata(q_item.z), .raddr(vert_addr), .rdata(rvz));

	// clamp the step limit into 1..4096
	always_comb begin
		if (step_limit == 13'd0)                  lim = 13'd1;
		else if (step_limit > bps_pkg::LIMIT_MAX) lim = bps_pkg::LIMIT_MAX;
		else                                      lim = step_limit;
	end

	// sign of the dot picks the child
	assign link = (sum_q <= 68'sd0) ? lb_q : la_q;

	// next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			bps_pkg::W_IDLE:
				if (take && q_item.cmd == bps_pkg::CMD_QUERY) st_nx = bps_pkg::W_NODE;
			bps_pkg::W_NODE:
				if (steps_q >= limit_q) st_nx = bps_pkg::W_DONE;
				else                    st_nx = bps_pkg::W_FACE;
			bps_pkg::W_FACE:
				if ({4'd0, rpf} >= 16'(bps_pkg::FACE_COUNT)) st_nx = bps_pkg::W_DONE;
				else                                          st_nx = bps_pkg::W_VERT;
			bps_pkg::W_VERT:
				if ({4'd0, rfv} >= 16'(bps_pkg::VERTEX_COUNT)) st_nx = bps_pkg::W_DONE;
				else                                            st_nx = bps_pkg::W_MUL;
			bps_pkg::W_MUL:    st_nx = bps_pkg::W_SUM;
			bps_pkg::W_SUM:    st_nx = bps_pkg::W_ADD;
			bps_pkg::W_ADD:    st_nx = bps_pkg::W_DECIDE;
			bps_pkg::W_DECIDE:
				if (link == bps_pkg::LINK_SOLID || link == bps_pkg::LINK_EMPTY
						|| {1'b0, link} >= 17'(bps_pkg::NODE_COUNT))
					st_nx = bps_pkg::W_DONE;
				else
					st_nx = bps_pkg::W_NODE;
			bps_pkg::W_DONE:   st_nx = bps_pkg::W_IDLE;
			default:           st_nx = bps_pkg::W_IDLE;
		endcase
	end

	// state, walk control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= bps_pkg::W_IDLE;
			walk_node_q <= '0;
			steps_q     <= '0;
			out_v_q     <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (st_q)
				bps_pkg::W_IDLE:
					if (take && q_item.cmd == bps_pkg::CMD_QUERY) begin
						walk_node_q <= '0;
						steps_q     <= '0;
					end
				bps_pkg::W_NODE: begin
					if (steps_q >= limit_q) begin
						res_q   <= '{1'b0, bps_pkg::ST_LIMIT, steps_q};
						out_v_q <= 1'b1;
					end else begin
						steps_q <= steps_q + 13'd1;
					end
				end
				bps_pkg::W_FACE:
					if ({4'd0, rpf} >= 16'(bps_pkg::FACE_COUNT)) begin
						res_q   <= '{1'b0, bps_pkg::ST_BAD, steps_q};
						out_v_q <= 1'b1;
					end
				bps_pkg::W_VERT:
					if ({4'd0, rfv} >= 16'(bps_pkg::VERTEX_COUNT)) begin
						res_q   <= '{1'b0, bps_pkg::ST_BAD, steps_q};
						out_v_q <= 1'b1;
					end
				bps_pkg::W_DECIDE: begin
					if (link == bps_pkg::LINK_SOLID) begin
						res_q   <= '{1'b1, bps_pkg::ST_OK, steps_q};
						out_v_q <= 1'b1;
					end else if (link == bps_pkg::LINK_EMPTY) begin
						res_q   <= '{1'b0, bps_pkg::ST_OK, steps_q};
						out_v_q <= 1'b1;
					end else if ({1'b0, link} >= 17'(bps_pkg::NODE_COUNT)) begin
						res_q   <= '{1'b0, bps_pkg::ST_BAD, steps_q};
						out_v_q <= 1'b1;
					end else begin
						walk_node_q <= NAW'(link);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers: item, node row, offsets, products, sum
	always_ff @(posedge clk) begin
		if (take) begin
			it_q    <= q_item;
			limit_q <= lim;
		end
		if (st_q == bps_pkg::W_FACE) begin
			nx_q   <= rnx;
			ny_q   <= rny;
			nz_q   <= rnz;
			la_q   <= rla;
			lb_q   <= rlb;
		end
		if (st_q == bps_pkg::W_MUL) begin
			ox_q <= 33'(signed'(it_q.x)) - 33'(signed'(rvx));
			oy_q <= 33'(signed'(it_q.y)) - 33'(signed'(rvy));
			oz_q <= 33'(signed'(it_q.z)) - 33'(signed'(rvz));
		end
		if (st_q == bps_pkg::W_SUM) begin
			px_q <= 66'(ox_q * signed'(nx_q));
			py_q <= 66'(oy_q * signed'(ny_q));
			pz_q <= 66'(oz_q * signed'(nz_q));
		end
		if (st_q == bps_pkg::W_ADD) begin
			sum_q <= 68'(px_q) + 68'(py_q) + 68'(pz_q);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {res_q.steps_taken, res_q.status, res_q.inside_res};

endmodule

// ----- hdl/bsp_point_in_solid.sv -----
// Top level: BSP point-in-solid tester, front classifier plus tree walker.
//  channel | dir | handshake          | contents
//  s_axis  | in  | s_tvalid/s_tready  | tuser cmd, tdata item fields
//  m_axis  | out | m_tvalid/m_tready  | tdata inside_res, status, steps_taken
//  cfg     | in  | cfg_valid/cfg_ready| step_limit
// Store writes go into the walker's RAMs as items are taken. A query walks
// the tree one node after another (node, face and vertex RAM reads in
// series, then offset, multiply, sum and decide).
// arst_n clears control state; the stores are undefined until written.
// A two-entry queue lets the input side keep taking items while a walk runs
// or a result waits on m_tready.
module bsp_point_in_solid (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [1:0]                s_tuser,   // cmd
	// index, coord_x, coord_y, coord_z, plane_face, link_above, link_below, first_vertex
	input  logic [bps_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// inside_res, status, steps_taken
	output logic [bps_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [12:0]               cfg_data   // step_limit
);

	logic           q_valid, q_ready;
	bps_pkg::item_t q_item;
	logic [12:0]    step_limit_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= bps_pkg::LIMIT_RST;
		end else if (cfg_valid) begin
			step_limit_q <= cfg_data;
		end
	end

	bps_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
		.q_valid, .q_ready, .q_item
	);

	bps_walk u_walk (
		.clk, .arst_n, .step_limit(step_limit_q),
		.q_valid, .q_ready, .q_item,
		.m_tvalid, .m_tready, .m_tdata
	);

	// a result never claims more steps than the largest clamped step limit, LIMIT_MAX
	a_steps_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:3] <= bps_pkg::LIMIT_MAX)
		else $error("steps above limit");

	// inside only with ok status
	a_inside_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[2:1] == bps_pkg::ST_OK)
		else $error("inside with error status");

	// a stalled result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// walker takes no item while a result waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !q_ready)
		else $error("item taken with result pending");

endmodule

// ----- tb/sv/tb_bsp_point_in_solid.sv -----
// Testbench for bsp_point_in_solid: directed and random tree loads and point queries checked by a scoreboard.
module tb_bsp_point_in_solid;

	// one input transaction before packing
	typedef struct {
		bps_pkg::cmd_t cmd;
		logic [11:0] index;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [11:0] plane_face;
		logic [15:0] link_above;
		logic [15:0] link_below;
		logic [11:0] first_vertex;
	} bsp_item_t;

	// tree stores, walk prediction and the queue of pending query results
	class bsp_scoreboard;
		logic [31:0] nrm_x[bps_pkg::NODE_COUNT], nrm_y[bps_pkg::NODE_COUNT];
		logic [31:0] nrm_z[bps_pkg::NODE_COUNT];
		logic [11:0] node_face[bps_pkg::NODE_COUNT];
		logic [15:0] node_above[bps_pkg::NODE_COUNT], node_below[bps_pkg::NODE_COUNT];
		bit          node_set[bps_pkg::NODE_COUNT];
		logic [11:0] face_vtx[bps_pkg::FACE_COUNT];
		bit          face_set[bps_pkg::FACE_COUNT];
		logic [31:0] vtx_x[bps_pkg::VERTEX_COUNT], vtx_y[bps_pkg::VERTEX_COUNT];
		logic [31:0] vtx_z[bps_pkg::VERTEX_COUNT];
		bit          vtx_set[bps_pkg::VERTEX_COUNT];
		logic [12:0] step_limit;
		bps_pkg::result_t pending[$];
		int          errors, loads, queries, solid_hits, bad_hits, limit_hits;

		function new();
			step_limit = bps_pkg::LIMIT_RST;
		endfunction

		// walk from node 0; unsafe is set when an unwritten entry would be read
		function void walk(input bsp_item_t it, output bps_pkg::result_t res,
				output bit unsafe);
			logic [12:0] lim, steps;
			int node, face, vtx;
			logic [15:0] link;
			logic signed [127:0] acc, a, b;
			longint ox, oy, oz;
			bit done;
			lim = (step_limit == 0) ? 13'd1 :
				(step_limit > bps_pkg::LIMIT_MAX) ? bps_pkg::LIMIT_MAX : step_limit;
			node = 0;
			steps = 0;
			unsafe = 0;
			done = 0;
			res = '{1'b0, bps_pkg::ST_OK, 13'd0};
			while (!done) begin
				if (steps >= lim) begin
					res = '{1'b0, bps_pkg::ST_LIMIT, steps};
					done = 1;
				end else begin
					steps++;
					if (!node_set[node]) begin
						unsafe = 1;
						done = 1;
					end else begin
						face = node_face[node];
						vtx = face_vtx[face];
						if (!face_set[face] || !vtx_set[vtx]) begin
							unsafe = 1;
							done = 1;
						end else begin
							ox = longint'($signed(it.x)) - longint'($signed(vtx_x[vtx]));
							oy = longint'($signed(it.y)) - longint'($signed(vtx_y[vtx]));
							oz = longint'($signed(it.z)) - longint'($signed(vtx_z[vtx]));
							a = ox; b = $signed(nrm_x[node]); acc = a * b;
							a = oy; b = $signed(nrm_y[node]); acc += a * b;
							a = oz; b = $signed(nrm_z[node]); acc += a * b;
							link = (acc <= 0) ? node_below[node] : node_above[node];
							if (link == bps_pkg::LINK_SOLID) begin
								res = '{1'b1, bps_pkg::ST_OK, steps};
								done = 1;
							end else if (link == bps_pkg::LINK_EMPTY) begin
								res = '{1'b0, bps_pkg::ST_OK, steps};
								done = 1;
							end else if (link >= bps_pkg::NODE_COUNT) begin
								res = '{1'b0, bps_pkg::ST_BAD, steps};
								done = 1;
							end else begin
								node = link;
							end
						end
					end
				end
			end
		endfunction

		// accepted input: update stores or queue the query's expected result
		function void note_item(bsp_item_t it);
			bps_pkg::result_t res;
			bit unsafe;
			case (it.cmd)
				bps_pkg::CMD_NODE: begin
					loads++;
					if (it.index < bps_pkg::NODE_COUNT) begin
						nrm_x[it.index] = it.x;
						nrm_y[it.index] = it.y;
						nrm_z[it.index] = it.z;
						node_face[it.index] = it.plane_face;
						node_above[it.index] = it.link_above;
						node_below[it.index] = it.link_below;
						node_set[it.index] = 1;
					end
				end
				bps_pkg::CMD_FACE: begin
					loads++;
					face_vtx[it.index] = it.first_vertex;
					face_set[it.index] = 1;
				end
				bps_pkg::CMD_VERTEX: begin
					loads++;
					vtx_x[it.index] = it.x;
					vtx_y[it.index] = it.y;
					vtx_z[it.index] = it.z;
					vtx_set[it.index] = 1;
				end
				default: begin
					walk(it, res, unsafe);
					pending.push_back(res);
					queries++;
					if (res.inside_res) solid_hits++;
					if (res.status == bps_pkg::ST_BAD) bad_hits++;
					if (res.status == bps_pkg::ST_LIMIT) limit_hits++;
				end
			endcase
		endfunction

		// accepted output transaction against the oldest expectation
		function void check_result(logic [bps_pkg::OUT_W-1:0] data);
			bps_pkg::result_t exp_r;
			if (pending.size() == 0) begin
				$error("result with no query outstanding: %h", data);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (data[0] !== exp_r.inside_res) begin
				$error("inside_res expected %0d got %0d", exp_r.inside_res, data[0]);
				errors++;
			end
			if (data[2:1] !== exp_r.status) begin
				$error("status expected %0d got %0d", exp_r.status, data[2:1]);
				errors++;
			end
			if (data[15:3] !== exp_r.steps_taken) begin
				$error("steps_taken expected %0d got %0d", exp_r.steps_taken, data[15:3]);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 0;
	logic                      arst_n = 0;
	logic                      s_tvalid = 0;
	logic                      s_tready;
	logic [1:0]                s_tuser = '0;
	logic [bps_pkg::IN_W-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 0;
	logic [bps_pkg::OUT_W-1:0] m_tdata;
	logic                      cfg_valid = 0;
	logic                      cfg_ready;
	logic [12:0]               cfg_data = '0;

	bsp_scoreboard sb = new();
	int            wfaces[$], wverts[$];
	int            results_seen;

	bsp_point_in_solid DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#60000000;
		$display("FAIL bsp_point_in_solid");
		$finish;
	end

	// idle draw: some stretches with no gaps at all
	function automatic int draw_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
	endfunction

	// drive one input transaction and wait for acceptance
	task automatic send_item(bsp_item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tuser <= it.cmd;
		s_tdata <= {4'b0, it.first_vertex, it.link_below, it.link_above, it.plane_face,
			it.z, it.y, it.x, it.index};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note_item(it);
		if (it.cmd != bps_pkg::CMD_QUERY) begin
			if (it.cmd == bps_pkg::CMD_FACE) wfaces.push_back(it.index);
			if (it.cmd == bps_pkg::CMD_VERTEX) wverts.push_back(it.index);
		end
	endtask

	// query only when the walk stays on written entries
	task automatic send_query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		bsp_item_t it;
		bps_pkg::result_t res;
		bit unsafe;
		it = '{bps_pkg::CMD_QUERY, 12'($urandom), x, y, z, 12'($urandom), 16'($urandom),
			16'($urandom), 12'($urandom)};
		sb.walk(it, res, unsafe);
		if (!unsafe) send_item(it);
	endtask

	task automatic load_node(int idx, logic [31:0] x, y, z, int face, int above, int below);
		send_item('{bps_pkg::CMD_NODE, 12'(idx), x, y, z, 12'(face), 16'(above),
			16'(below), 12'($urandom)});
	endtask

	task automatic load_face(int idx, int vtx);
		send_item('{bps_pkg::CMD_FACE, 12'(idx), $urandom, $urandom, $urandom,
			12'($urandom), 16'($urandom), 16'($urandom), 12'(vtx)});
	endtask

	task automatic load_vertex(int idx, logic [31:0] x, y, z);
		send_item('{bps_pkg::CMD_VERTEX, 12'(idx), x, y, z, 12'($urandom), 16'($urandom),
			16'($urandom), 12'($urandom)});
	endtask

	// wait out every pending result plus the queue's tail of loads
	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_limit(logic [12:0] v);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.step_limit = v;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 64) - 32;
			1: return 32'h8000_0000 | $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_link();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return 16'($urandom_range(0, 15));
		if (r < 60) return bps_pkg::LINK_SOLID;
		if (r < 85) return bps_pkg::LINK_EMPTY;
		if (r < 95) return 16'($urandom_range(bps_pkg::NODE_COUNT, 16'hFFFD));
		return 16'($urandom_range(0, bps_pkg::NODE_COUNT - 1));
	endfunction

	// one random transaction, mostly tree loads into a small working set
	task automatic random_item();
		int r, idx;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			if ($urandom_range(0, 1)) send_query(rand_coord(), rand_coord(), rand_coord());
			else send_query($urandom, $urandom, $urandom);
		end else if (r < 52) begin
			idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 15);
			load_vertex(idx, rand_coord(), rand_coord(), rand_coord());
		end else if (r < 65) begin
			idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 15);
			load_face(idx, wverts[$urandom_range(0, wverts.size() - 1)]);
		end else if (r < 96) begin
			idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
			load_node(idx, $urandom, $urandom, $urandom,
				wfaces[$urandom_range(0, wfaces.size() - 1)], rand_link(), rand_link());
		end else begin
			// slot past the node store: dropped by the block
			load_node($urandom_range(bps_pkg::NODE_COUNT, 4095), $urandom, $urandom, $urandom,
				wfaces[$urandom_range(0, wfaces.size() - 1)], bps_pkg::LINK_SOLID,
				bps_pkg::LINK_SOLID);
		end
	endtask

	// result side, with one long hold-off so the input queue backs up
	initial begin
		int gap;
		results_seen = 0;
		forever begin
			gap = (results_seen == 12) ? 400 : draw_gap();
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
			results_seen++;
		end
	end

	initial begin
		logic [12:0] phase_limits[8];
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extreme vertices, faces and a small tree
		load_vertex(0, 32'h0, 32'h0, 32'h0);
		load_vertex(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		load_vertex(4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		load_face(0, 0);
		load_face(1, 1);
		load_face(4095, 4095);
		load_node(0, 32'h4000_0000, 32'h0, 32'h0, 0, 1, 2);
		load_node(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, bps_pkg::LINK_SOLID,
			bps_pkg::LINK_EMPTY);
		load_node(2, 32'h0, 32'h0, 32'h7FFF_FFFF, 4095, bps_pkg::NODE_COUNT, 16'hFFFD);
		load_node(2000, 32'h0, 32'h0, 32'h0, 0, bps_pkg::LINK_SOLID, bps_pkg::LINK_SOLID);
		send_query(32'h0, 32'h0, 32'h0);
		send_query(32'h1, 32'h0, 32'h0);
		send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		load_node(3, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 0, 3, 3);
		load_node(1, 32'h8000_0000, 32'h0, 32'h0, 1, 3, bps_pkg::LINK_EMPTY);
		send_query(32'hFFFF_0000, 32'h0, 32'h0);
		send_query(32'h0000_1000, 32'h0, 32'h0);
		drain();

		// random phases over several step limits, extremes included
		phase_limits = '{13'd1, 13'd8191, 13'd0, 13'd4096, 13'd2, 13'd7, 13'd20, 13'd64};
		foreach (phase_limits[p]) begin
			write_limit(phase_limits[p]);
			repeat ((phase_limits[p] >= bps_pkg::LIMIT_MAX) ? 25 : 75) random_item();
			drain();
		end
		write_limit(bps_pkg::LIMIT_RST);
		repeat (20) random_item();
		drain();

		$display("covered %0d loads and %0d queries: %0d solid, %0d bad link, %0d step limit",
			sb.loads, sb.queries, sb.solid_hits, sb.bad_hits, sb.limit_hits);
		if (sb.errors == 0) begin
			$display("PASS bsp_point_in_solid");
		end else begin
			$display("FAIL bsp_point_in_solid");
		end
		$finish;
	end
endmodule
